// ===== rtl/ssg_pkg.sv =====
package ssg_pkg;

   // Fixed point format of the relaxed values
   localparam int FRAC_BITS = 16;
   localparam int VALUE_W   = FRAC_BITS + 1;
   localparam logic [VALUE_W-1:0] ONE  = VALUE_W'(1) << FRAC_BITS;
   localparam logic [VALUE_W-1:0] HALF = VALUE_W'(1) << (FRAC_BITS - 1);

   // Field widths
   localparam int INDEX_W = 10;
   localparam int REG_W   = 11;
   localparam int GRAD_W  = 28;
   localparam int TOTAL_W = 27;
   localparam int COUNT_W = 11;
   localparam int REQ_W   = 64;
   localparam int RSP_W   = 72;

   // Default store depths
   localparam int DEF_CLAUSE_DEPTH = 1024;
   localparam int DEF_VAR_DEPTH    = 1024;

   typedef enum logic [1:0] {
      CMD_LOAD_CLAUSE = 2'd0,
      CMD_WRITE_VAR   = 2'd1,
      CMD_EVALUATE    = 2'd2,
      CMD_READ_GRAD   = 2'd3
   } cmd_type;

   typedef enum logic [0:0] {
      REG_CLAUSE_COUNT   = 1'b0,
      REG_VARIABLE_COUNT = 1'b1
   } reg_type;

endpackage

// ===== rtl/ssg_ram.sv =====
module ssg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== rtl/ssg_wrap.sv =====
module ssg_wrap #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                        clock,
   input  logic [ssg_pkg::INDEX_W-1:0] x,
   output logic [AW-1:0]               r
);

   // Reduce an index modulo DEPTH: reciprocal multiply, then one correction.
   // x must hold steady while q_ff and then r_ff are registered from it.
   localparam logic [20:0] RECIP = 21'((32'd1 << 20) / DEPTH);
   localparam logic [17:0] DV    = 18'(DEPTH);

   logic [30:0] qx;
   logic [9:0]  q_ff, q_in;
   logic [27:0] qd;
   logic [27:0] r_full;
   logic [17:0] r_fix;
   logic [AW-1:0] r_ff, r_in;

   always_comb begin
      qx     = 31'(x) * 31'(RECIP);
      q_in   = qx[29:20];
      qd     = 28'(q_ff) * 28'(DV);
      r_full = 28'(x) - qd;
      r_fix  = r_full[17:0];
      if (r_fix >= DV) begin
         r_fix = r_fix - DV;
      end
      r_in = r_fix[AW-1:0];
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
   end

   assign r = r_ff;

endmodule

// ===== rtl/soft_sat_clause_gradient_engine.sv =====
// Soft 3-SAT clause gradient engine. Clauses, variable values and gradients
// live in three single-port-read synchronous memories. After reset the block
// clears every entry of the gradient memory, one entry a cycle, and takes
// no item meanwhile (register writes are taken). Every item gives one result.
// Evaluate first clears the gradients of the variables in use; then each
// clause needs one clause read and three value reads from the value memory,
// two registered multiply steps and, when its product is nonzero, three
// read-modify-writes of the gradient memory. One item is worked on at a time;
// a finished result may wait in the output register while the next item is
// taken.
module soft_sat_clause_gradient_engine #(
   parameter int CLAUSE_DEPTH = ssg_pkg::DEF_CLAUSE_DEPTH,
   parameter int VAR_DEPTH    = ssg_pkg::DEF_VAR_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   // tdata: index[9:0], var_a[19:10], var_b[29:20], var_c[39:30], neg_a[40],
   // neg_b[41], neg_c[42], value[59:43], zero fill
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [ssg_pkg::REQ_W-1:0]   req_tdata,
   // tuser: cmd[1:0]
   input  logic [1:0]                  req_tuser,
   // tdata: soft_total[26:0], sat_count[37:27], gradient[65:38], zero fill
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [ssg_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [0:0]                  csr_index,
   input  logic [ssg_pkg::REG_W-1:0]   csr_data
);

   localparam int CAW = CLAUSE_DEPTH > 1 ? $clog2(CLAUSE_DEPTH) : 1;
   localparam int VAW = VAR_DEPTH > 1 ? $clog2(VAR_DEPTH) : 1;
   localparam int CCW = $clog2(CLAUSE_DEPTH + 1);
   localparam int VCW = $clog2(VAR_DEPTH + 1);
   localparam int CMW = 3 * VAW + 3;
   localparam int VW  = ssg_pkg::VALUE_W;
   localparam int GW  = ssg_pkg::GRAD_W;
   localparam int TW  = ssg_pkg::TOTAL_W;
   localparam int SW  = ssg_pkg::COUNT_W;
   localparam int IW  = ssg_pkg::INDEX_W;
   localparam int FB  = ssg_pkg::FRAC_BITS;

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_W1, S_W2, S_EXEC, S_CLR, S_CRD,
      S_V0, S_V1, S_V2, S_V3, S_M1, S_M2, S_ACC, S_GRD, S_GWR, S_RGD, S_DONE
   } state_type;

   state_type state_ff, state_in;

   // Registers and captured item
   logic [ssg_pkg::REG_W-1:0] clause_count_ff, clause_count_in;
   logic [ssg_pkg::REG_W-1:0] variable_count_ff, variable_count_in;
   ssg_pkg::cmd_type          cmd_ff, cmd_in;
   logic [IW-1:0]             index_ff, index_in;
   logic [IW-1:0]             var_a_ff, var_a_in, var_b_ff, var_b_in, var_c_ff, var_c_in;
   logic [2:0]                negs_ff, negs_in;
   logic [VW-1:0]             value_ff, value_in;

   // Wrapped addresses
   logic [CAW-1:0] cidx;
   logic [VAW-1:0] vidx, wa, wb, wc;

   // Evaluation datapath
   logic [CCW-1:0] ci_ff, ci_in, clause_lim;
   logic [VCW-1:0] vi_ff, vi_in, var_lim;
   logic [VAW-1:0] cv_ff [3];
   logic [VAW-1:0] cv_in [3];
   logic [2:0]     cn_ff, cn_in;
   logic [VW-1:0]  t_ff [3];
   logic [VW-1:0]  t_in [3];
   logic           hit_ff, hit_in;
   logic [VW-1:0]  p01_ff, p01_in, m02_ff, m02_in, m12_ff, m12_in, prod_ff, prod_in;
   logic [1:0]     gj_ff, gj_in;
   logic [TW-1:0]  total_ff, total_in;
   logic [SW-1:0]  sat_ff, sat_in;

   // Result
   logic [TW-1:0]  res_total_ff, res_total_in;
   logic [SW-1:0]  res_sat_ff, res_sat_in;
   logic [GW-1:0]  res_grad_ff, res_grad_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [ssg_pkg::RSP_W-1:0] rsp_data_ff, rsp_data_in;

   // Memory ports
   logic           c_we;
   logic [CAW-1:0] c_waddr, c_raddr;
   logic [CMW-1:0] c_wdata, c_rdata;
   logic           v_we;
   logic [VAW-1:0] v_waddr, v_raddr;
   logic [VW-1:0]  v_rdata;
   logic           g_we;
   logic [VAW-1:0] g_waddr, g_raddr;
   logic [GW-1:0]  g_wdata, g_rdata;

   // Temporaries
   logic [2*VW-1:0] mul_a, mul_b, mul_c;
   logic [TW:0]     tot_sum;
   logic [GW:0]     g_sum;
   logic [VW-1:0]   amount;
   logic [VAW-1:0]  lane_var;
   logic            lane_neg;

   // t = 1 - literal, clamped to one LSB
   function automatic logic [VW-1:0] t_of(input logic [VW-1:0] x, input logic neg);
      logic [VW-1:0] xc;
      logic [VW-1:0] t;
      xc = (x > ssg_pkg::ONE) ? ssg_pkg::ONE : x;
      t  = neg ? xc : ssg_pkg::ONE - xc;
      if (t == '0) begin
         t = VW'(1);
      end
      return t;
   endfunction

   function automatic logic hit_of(input logic [VW-1:0] x, input logic neg);
      return (x > ssg_pkg::HALF) != neg;
   endfunction

   ssg_wrap #(.DEPTH(CLAUSE_DEPTH), .AW(CAW)) u_wrap_ci (.clock, .x(index_ff), .r(cidx));
   ssg_wrap #(.DEPTH(VAR_DEPTH), .AW(VAW)) u_wrap_vi (.clock, .x(index_ff), .r(vidx));
   ssg_wrap #(.DEPTH(VAR_DEPTH), .AW(VAW)) u_wrap_a (.clock, .x(var_a_ff), .r(wa));
   ssg_wrap #(.DEPTH(VAR_DEPTH), .AW(VAW)) u_wrap_b (.clock, .x(var_b_ff), .r(wb));
   ssg_wrap #(.DEPTH(VAR_DEPTH), .AW(VAW)) u_wrap_c (.clock, .x(var_c_ff), .r(wc));

   ssg_ram #(.WIDTH(CMW), .DEPTH(CLAUSE_DEPTH), .AW(CAW)) u_clause_mem (
      .clock, .we(c_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(c_raddr), .rdata(c_rdata)
   );
   ssg_ram #(.WIDTH(VW), .DEPTH(VAR_DEPTH), .AW(VAW)) u_value_mem (
      .clock, .we(v_we), .waddr(v_waddr), .wdata(value_ff), .raddr(v_raddr), .rdata(v_rdata)
   );
   ssg_ram #(.WIDTH(GW), .DEPTH(VAR_DEPTH), .AW(VAW)) u_grad_mem (
      .clock, .we(g_we), .waddr(g_waddr), .wdata(g_wdata), .raddr(g_raddr), .rdata(g_rdata)
   );

   // Counts saturated to the store depths
   always_comb begin
      if (32'(clause_count_ff) > 32'(CLAUSE_DEPTH)) begin
         clause_lim = CCW'(CLAUSE_DEPTH);
      end else begin
         clause_lim = CCW'(clause_count_ff);
      end
      if (32'(variable_count_ff) > 32'(VAR_DEPTH)) begin
         var_lim = VCW'(VAR_DEPTH);
      end else begin
         var_lim = VCW'(variable_count_ff);
      end
   end

   // Gradient lane selection
   always_comb begin
      lane_var = cv_ff[0];
      lane_neg = cn_ff[0];
      amount   = m12_ff;
      case (gj_ff)
         2'd1: begin
            lane_var = cv_ff[1];
            lane_neg = cn_ff[1];
            amount   = m02_ff;
         end
         2'd2: begin
            lane_var = cv_ff[2];
            lane_neg = cn_ff[2];
            amount   = p01_ff;
         end
         default: begin
            lane_var = cv_ff[0];
            lane_neg = cn_ff[0];
            amount   = m12_ff;
         end
      endcase
   end

   // Next state and datapath
   always_comb begin
      state_in          = state_ff;
      clause_count_in   = clause_count_ff;
      variable_count_in = variable_count_ff;
      cmd_in   = cmd_ff;
      index_in = index_ff;
      var_a_in = var_a_ff;
      var_b_in = var_b_ff;
      var_c_in = var_c_ff;
      negs_in  = negs_ff;
      value_in = value_ff;
      ci_in    = ci_ff;
      vi_in    = vi_ff;
      cv_in    = cv_ff;
      cn_in    = cn_ff;
      t_in     = t_ff;
      hit_in   = hit_ff;
      p01_in   = p01_ff;
      m02_in   = m02_ff;
      m12_in   = m12_ff;
      prod_in  = prod_ff;
      gj_in    = gj_ff;
      total_in = total_ff;
      sat_in   = sat_ff;
      res_total_in = res_total_ff;
      res_sat_in   = res_sat_ff;
      res_grad_in  = res_grad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;
      c_we    = 1'b0;
      c_waddr = cidx;
      c_wdata = {negs_ff[2], negs_ff[1], negs_ff[0], wc, wb, wa};
      c_raddr = ci_ff[CAW-1:0];
      v_we    = 1'b0;
      v_waddr = vidx;
      v_raddr = cv_ff[0];
      g_we    = 1'b0;
      g_waddr = vi_ff[VAW-1:0];
      g_wdata = '0;
      g_raddr = lane_var;

      mul_a   = (2*VW)'(t_ff[0]) * (2*VW)'(t_ff[1]);
      mul_b   = (2*VW)'(t_ff[0]) * (2*VW)'(t_ff[2]);
      mul_c   = (2*VW)'(t_ff[1]) * (2*VW)'(t_ff[2]);
      tot_sum = (TW+1)'(total_ff) + (TW+1)'(ssg_pkg::ONE - prod_ff);
      if (lane_neg) begin
         g_sum = {g_rdata[GW-1], g_rdata} - (GW+1)'(amount);
      end else begin
         g_sum = {g_rdata[GW-1], g_rdata} + (GW+1)'(amount);
      end

      // Configuration writes
      if (csr_valid) begin
         case (csr_index)
            ssg_pkg::REG_CLAUSE_COUNT:   clause_count_in = csr_data;
            ssg_pkg::REG_VARIABLE_COUNT: variable_count_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         // Clear the gradient store after reset
         S_INIT: begin
            g_we    = 1'b1;
            g_waddr = vi_ff[VAW-1:0];
            vi_in   = vi_ff + VCW'(1);
            if (vi_ff == VCW'(VAR_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_in   = ssg_pkg::cmd_type'(req_tuser);
               index_in = req_tdata[9:0];
               var_a_in = req_tdata[19:10];
               var_b_in = req_tdata[29:20];
               var_c_in = req_tdata[39:30];
               negs_in  = req_tdata[42:40];
               value_in = req_tdata[59:43];
               state_in = S_W1;
            end
         end
         // Index wrapping pipeline
         S_W1: state_in = S_W2;
         S_W2: state_in = S_EXEC;
         S_EXEC: begin
            res_total_in = '0;
            res_sat_in   = '0;
            res_grad_in  = '0;
            case (cmd_ff)
               ssg_pkg::CMD_LOAD_CLAUSE: begin
                  c_we     = 1'b1;
                  state_in = S_DONE;
               end
               ssg_pkg::CMD_WRITE_VAR: begin
                  v_we     = 1'b1;
                  state_in = S_DONE;
               end
               ssg_pkg::CMD_EVALUATE: begin
                  total_in = '0;
                  sat_in   = '0;
                  ci_in    = '0;
                  vi_in    = '0;
                  state_in = S_CLR;
               end
               ssg_pkg::CMD_READ_GRAD: begin
                  g_raddr  = vidx;
                  state_in = S_RGD;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_RGD: begin
            res_grad_in = g_rdata;
            state_in    = S_DONE;
         end
         // Clear gradients of the variables in use
         S_CLR: begin
            if (vi_ff == var_lim) begin
               state_in = S_CRD;
            end else begin
               g_we    = 1'b1;
               g_waddr = vi_ff[VAW-1:0];
               vi_in   = vi_ff + VCW'(1);
            end
         end
         // Next clause, or finish
         S_CRD: begin
            hit_in = 1'b0;
            if (ci_ff == clause_lim) begin
               res_total_in = total_ff;
               res_sat_in   = sat_ff;
               state_in     = S_DONE;
            end else begin
               c_raddr  = ci_ff[CAW-1:0];
               state_in = S_V0;
            end
         end
         S_V0: begin
            cv_in[0] = c_rdata[VAW-1:0];
            cv_in[1] = c_rdata[2*VAW-1:VAW];
            cv_in[2] = c_rdata[3*VAW-1:2*VAW];
            cn_in    = c_rdata[CMW-1:3*VAW];
            v_raddr  = c_rdata[VAW-1:0];
            state_in = S_V1;
         end
         S_V1: begin
            t_in[0]  = t_of(v_rdata, cn_ff[0]);
            hit_in   = hit_ff | hit_of(v_rdata, cn_ff[0]);
            v_raddr  = cv_ff[1];
            state_in = S_V2;
         end
         S_V2: begin
            t_in[1]  = t_of(v_rdata, cn_ff[1]);
            hit_in   = hit_ff | hit_of(v_rdata, cn_ff[1]);
            v_raddr  = cv_ff[2];
            state_in = S_V3;
         end
         S_V3: begin
            t_in[2]  = t_of(v_rdata, cn_ff[2]);
            hit_in   = hit_ff | hit_of(v_rdata, cn_ff[2]);
            state_in = S_M1;
         end
         // Pairwise products, truncated; then the product of all three
         S_M1: begin
            p01_in   = mul_a[FB+VW-1:FB];
            m02_in   = mul_b[FB+VW-1:FB];
            m12_in   = mul_c[FB+VW-1:FB];
            state_in = S_M2;
         end
         S_M2: begin
            mul_a    = (2*VW)'(p01_ff) * (2*VW)'(t_ff[2]);
            prod_in  = mul_a[FB+VW-1:FB];
            state_in = S_ACC;
         end
         S_ACC: begin
            total_in = tot_sum[TW] ? '1 : tot_sum[TW-1:0];
            if (hit_ff && sat_ff != '1) begin
               sat_in = sat_ff + SW'(1);
            end
            if (prod_ff != '0) begin
               gj_in    = 2'd0;
               state_in = S_GRD;
            end else begin
               ci_in    = ci_ff + CCW'(1);
               state_in = S_CRD;
            end
         end
         // Gradient read-modify-write, one literal at a time
         S_GRD: begin
            g_raddr  = lane_var;
            state_in = S_GWR;
         end
         S_GWR: begin
            g_we    = 1'b1;
            g_waddr = lane_var;
            if (g_sum[GW] != g_sum[GW-1]) begin
               g_wdata = g_sum[GW] ? {1'b1, {(GW-1){1'b0}}} : {1'b0, {(GW-1){1'b1}}};
            end else begin
               g_wdata = g_sum[GW-1:0];
            end
            if (gj_ff == 2'd2) begin
               ci_in    = ci_ff + CCW'(1);
               state_in = S_CRD;
            end else begin
               gj_in    = gj_ff + 2'd1;
               state_in = S_GRD;
            end
         end
         // Hand the result to the output register
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {6'b0, res_grad_ff, res_sat_ff, res_total_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_INIT;
         clause_count_ff   <= '0;
         variable_count_ff <= '0;
         vi_ff             <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         clause_count_ff   <= clause_count_in;
         variable_count_ff <= variable_count_in;
         vi_ff             <= vi_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      index_ff     <= index_in;
      var_a_ff     <= var_a_in;
      var_b_ff     <= var_b_in;
      var_c_ff     <= var_c_in;
      negs_ff      <= negs_in;
      value_ff     <= value_in;
      ci_ff        <= ci_in;
      cv_ff        <= cv_in;
      cn_ff        <= cn_in;
      t_ff         <= t_in;
      hit_ff       <= hit_in;
      p01_ff       <= p01_in;
      m02_ff       <= m02_in;
      m12_ff       <= m12_in;
      prod_ff      <= prod_in;
      gj_ff        <= gj_in;
      total_ff     <= total_in;
      sat_ff       <= sat_in;
      res_total_ff <= res_total_in;
      res_sat_ff   <= res_sat_in;
      res_grad_ff  <= res_grad_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

endmodule
